>>> sv/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the palette index pixel packer.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_ENTRIES = 3;
    localparam int COLOR_W     = 12;
    localparam int PAL_W       = MAX_ENTRIES * COLOR_W;
    localparam int WORD_W      = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [0:0] REG_ALPHA_THRESHOLD = 1'b0;
    localparam logic [3:0] THRESH_RESET        = 4'hF;

    typedef logic [COLOR_W-1:0] rgb_t;
    typedef logic [1:0]         pal_idx_t;
    typedef logic [1:0]         used_t;
    typedef logic [PAL_W-1:0]   pal_t;

    // classified pixel handed from front to back
    typedef struct packed {
        pal_idx_t idx;
        logic     last;
        logic     ovf;
        used_t    used;
        pal_t     pal;
    } q_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              last_word;
        logic              overflow_seen;
        used_t             colors_used;
        pal_t              palette_colors;
    } word_t;

endpackage

>>> sv/pip_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pixel_if
// Pixel channel: RGBA8888 plus end-of-image mark, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;

    modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

>>> sv/pip_word_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_word_if
// Packed word channel: indices, palette and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] packed_word;
    logic        last_word;
    logic        overflow_seen;
    logic [1:0]  colors_used;
    logic [35:0] palette_colors;

    modport source (output valid, packed_word, last_word, overflow_seen, colors_used,
                    palette_colors, input ready);
    modport sink   (input valid, packed_word, last_word, overflow_seen, colors_used,
                    palette_colors, output ready);
endinterface

>>> sv/palette_index_pixel_packer_top.sv
`timescale 1ns / 1ps
// A word's final pixel is registered in the queue, then the word in the output register.
// Throughput: one pixel per cycle if the queue has room, set by the palette compare and
// allocate in the front; at most one word per cycle leaves the output register.
// Reset (rst_n, async, active low) empties the queue and output register, clears
// the palette, packer and overflow flag, and sets alpha_threshold to 15.
// ----------------------------------------------------------------------------
// palette_index_pixel_packer_top
// RGBA pixels in, packed 2-bit palette indices out, APB threshold register.
// ----------------------------------------------------------------------------
module palette_index_pixel_packer_top #(
    parameter int INDEX_BITS      = 2,
    parameter int PIXELS_PER_WORD = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    pip_pixel_if.sink                  pixels,
    pip_word_if.source                 words,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pip_pkg::APB_AW-1:0] paddr,
    input  logic [pip_pkg::APB_DW-1:0] pwdata,
    output logic [pip_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pip_pkg::*;

    logic [3:0] thresh_reg;
    logic       thresh_sel;
    q_item_t    push_item;
    logic       push_valid;
    logic       push_ready;
    q_item_t    pop_item;
    logic       pop_valid;
    logic       pop_ready;

    assign pready     = 1'b1;
    assign thresh_sel = (paddr[2] == REG_ALPHA_THRESHOLD);
    assign prdata     = thresh_sel ? APB_DW'(thresh_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready && thresh_sel)
        begin
            thresh_reg <= pwdata[3:0];
        end
    end

    pip_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .alpha_threshold (thresh_reg),
        .pixels          (pixels),
        .push_item       (push_item),
        .push_valid      (push_valid),
        .push_ready      (push_ready)
    );

    pip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    pip_back #(
        .INDEX_BITS      (INDEX_BITS),
        .PIXELS_PER_WORD (PIXELS_PER_WORD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .words     (words)
    );

endmodule

>>> sv/pip_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_front
// Reduces pixels to RGB444/A4, looks up or allocates a palette entry and
// pushes the index with a palette snapshot into the queue.
// ----------------------------------------------------------------------------
module pip_front #(
    parameter int INDEX_BITS = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         alpha_threshold,
    pip_pixel_if.sink          pixels,
    output pip_pkg::q_item_t   push_item,
    output logic               push_valid,
    input  logic               push_ready
);
    import pip_pkg::*;

    localparam int IDX_LIMIT   = (1 << INDEX_BITS) - 1;
    localparam int ENTRY_LIMIT = (IDX_LIMIT < MAX_ENTRIES) ? IDX_LIMIT : MAX_ENTRIES;

    rgb_t                   store_reg [MAX_ENTRIES];
    rgb_t                   store_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic                   ovf_reg;
    logic                   ovf_next;

    rgb_t     rgb;
    logic [3:0] a4;
    logic     transparent;
    logic     hit_any;
    logic     free_any;
    pal_idx_t hit_idx;
    pal_idx_t free_idx;
    pal_idx_t idx;
    logic     accept;

    assign rgb         = {pixels.red[7:4], pixels.green[7:4], pixels.blue[7:4]};
    assign a4          = pixels.alpha[7:4];
    assign transparent = (rgb == '0) || (a4 < alpha_threshold);
    assign accept      = pixels.valid && push_ready;

    // palette fills in order, so a hit always sits below the first free entry
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int j = MAX_ENTRIES - 1; j >= 0; j--)
        begin
            if (j < ENTRY_LIMIT)
            begin
                if (valid_reg[j] && (store_reg[j] == rgb))
                begin
                    hit_any = 1'b1;
                    hit_idx = pal_idx_t'(j + 1);
                end
                if (!valid_reg[j])
                begin
                    free_any = 1'b1;
                    free_idx = pal_idx_t'(j);
                end
            end
        end
    end

    always_comb
    begin
        store_next = store_reg;
        valid_next = valid_reg;
        ovf_next   = ovf_reg;
        idx        = '0;
        if (!transparent)
        begin
            if (hit_any)
            begin
                idx = hit_idx;
            end
            else if (free_any)
            begin
                idx                  = free_idx + pal_idx_t'(1);
                store_next[free_idx] = rgb;
                valid_next[free_idx] = 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        push_item.idx  = idx;
        push_item.last = pixels.last_pixel;
        push_item.ovf  = ovf_next;
        push_item.used = used_t'($countones(valid_next));
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            push_item.pal[j*COLOR_W +: COLOR_W] = valid_next[j] ? store_next[j] : '0;
        end
    end

    assign push_valid   = pixels.valid;
    assign pixels.ready = push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            ovf_reg   <= ovf_next;
            valid_reg <= pixels.last_pixel ? '0 : valid_next;
        end
    end

    // entries are only read while valid, so the colors need no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
    end

endmodule

>>> sv/pip_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_queue
// Two-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module pip_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  pip_pkg::q_item_t push_item,
    input  logic             push_valid,
    output logic             push_ready,
    output pip_pkg::q_item_t pop_item,
    output logic             pop_valid,
    input  logic             pop_ready
);
    import pip_pkg::*;

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/pip_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_back
// Packs indices into 16-bit words, first pixel in the top bits, and holds
// the finished word in an output register.
// ----------------------------------------------------------------------------
module pip_back #(
    parameter int INDEX_BITS      = 2,
    parameter int PIXELS_PER_WORD = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pip_pkg::q_item_t pop_item,
    input  logic             pop_valid,
    output logic             pop_ready,
    pip_word_if.source       words
);
    import pip_pkg::*;

    localparam int SLOT_W = (PIXELS_PER_WORD > 1) ? $clog2(PIXELS_PER_WORD) : 1;
    localparam int SHW    = $clog2(PIXELS_PER_WORD * INDEX_BITS) + 5;

    logic [WORD_W-1:0] accum_reg;
    logic [WORD_W-1:0] accum_next;
    logic [SLOT_W-1:0] slot_reg;
    word_t             out_reg;
    logic              out_valid_reg;

    logic [SHW-1:0]    shift;
    logic [WORD_W-1:0] contrib;
    logic              full;
    logic              emit;
    logic              take;

    assign shift = SHW'((SHW'(PIXELS_PER_WORD - 1) - SHW'(slot_reg)) * SHW'(INDEX_BITS));
    // slots past bit 15 are dropped
    assign contrib    = (shift < SHW'(WORD_W)) ? (WORD_W'(pop_item.idx) << shift[3:0]) : '0;
    assign accum_next = accum_reg | contrib;
    assign full       = (slot_reg == SLOT_W'(PIXELS_PER_WORD - 1));
    assign emit       = full || pop_item.last;
    assign take       = pop_valid && (!emit || !out_valid_reg || words.ready);
    assign pop_ready  = !emit || !out_valid_reg || words.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (emit)
                begin
                    accum_reg <= '0;
                    slot_reg  <= '0;
                end
                else
                begin
                    accum_reg <= accum_next;
                    slot_reg  <= slot_reg + SLOT_W'(1);
                end
            end
            if (take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (words.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg.packed_word    <= accum_next;
            out_reg.last_word      <= pop_item.last;
            out_reg.overflow_seen  <= pop_item.ovf;
            out_reg.colors_used    <= pop_item.used;
            out_reg.palette_colors <= pop_item.pal;
        end
    end

    assign words.valid          = out_valid_reg;
    assign words.packed_word    = out_reg.packed_word;
    assign words.last_word      = out_reg.last_word;
    assign words.overflow_seen  = out_reg.overflow_seen;
    assign words.colors_used    = out_reg.colors_used;
    assign words.palette_colors = out_reg.palette_colors;

endmodule
